@@ rtl/bounded_undo_redo_history_assert.svh @@
// Assertion helpers used by the history control block.
// Each macro samples on clk and is disabled while rst_n is low.
`ifndef BOUNDED_UNDO_REDO_HISTORY_ASSERT_SVH
`define BOUNDED_UNDO_REDO_HISTORY_ASSERT_SVH

// Same-cycle implication.
`define BUH_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define BUH_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/buh_pkg.sv @@
package buh_pkg;

  // Field widths of the transfer payloads.
  localparam int OPCODE_W      = 3;
  localparam int ENTRY_W       = 32;
  localparam int ACTION_W      = 2;
  localparam int UNDO_DEPTH_W  = 7;

  // Default number of history entries.
  localparam int HISTORY_DEPTH_DEF = 64;

  // Operation codes carried by in_opcode.
  typedef enum logic [OPCODE_W-1:0] {
    OP_PUSH_EXEC = 3'd0,
    OP_PUSH_ONLY = 3'd1,
    OP_UNDO      = 3'd2,
    OP_REDO      = 3'd3,
    OP_CLEAR     = 3'd4
  } op_t;

  // Action codes carried by out_action.
  typedef enum logic [ACTION_W-1:0] {
    ACT_NONE   = 2'd0,
    ACT_EXEC   = 2'd1,
    ACT_REVERT = 2'd2
  } action_t;

  // Shift command broadcast to every cell of the history row.
  typedef enum logic [3:0] {
    SH_HOLD = 4'b0001,
    SH_PUSH = 4'b0010,
    SH_UNDO = 4'b0100,
    SH_REDO = 4'b1000
  } shift_t;

endpackage

@@ rtl/bounded_undo_redo_history.sv @@
// Channel   Direction  Handshake            Payload
// in_       input      in_valid / in_stall  in_opcode, in_entry_handle
// out_      output     out_valid / out_stall out_accepted, out_action,
//                                           out_entry_out, out_undo_depth
//
// One operation per cycle while in_stall is low; each result is registered and appears in the cycle after its transfer.
// The history is a row of cells that shifts by one place on every accepted push, undo or redo.
// Reset (rst_n low at a clock edge) empties the history and drops any pending result.
// in_stall rises only while a result is waiting and out_stall is high.
module bounded_undo_redo_history #(
  parameter int HISTORY_DEPTH = buh_pkg::HISTORY_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [buh_pkg::OPCODE_W-1:0]      in_opcode,
  input  logic [buh_pkg::ENTRY_W-1:0]       in_entry_handle,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              out_accepted,
  output logic [buh_pkg::ACTION_W-1:0]      out_action,
  output logic [buh_pkg::ENTRY_W-1:0]       out_entry_out,
  output logic [buh_pkg::UNDO_DEPTH_W-1:0]  out_undo_depth
);
  import buh_pkg::*;

  logic [ENTRY_W-1:0] l_q [HISTORY_DEPTH];
  logic [ENTRY_W-1:0] r_q [HISTORY_DEPTH];
  logic [ENTRY_W-1:0] head_l_in;
  shift_t             shift;

  // Control, cursor and result register.
  buh_ctrl #(
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_opcode       (in_opcode),
    .in_entry_handle (in_entry_handle),
    .head_l          (l_q[0]),
    .head_r          (r_q[0]),
    .shift           (shift),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_accepted    (out_accepted),
    .out_action      (out_action),
    .out_entry_out   (out_entry_out),
    .out_undo_depth  (out_undo_depth)
  );

  // A push feeds the new handle into the head; a redo feeds the head redo entry.
  assign head_l_in = (shift == SH_PUSH) ? in_entry_handle : r_q[0];

  // Row of cells; the last cell refills from itself, so the oldest entry falls off.
  for (genvar k = 0; k < HISTORY_DEPTH; k++) begin : g_cell
    logic [ENTRY_W-1:0] l_prev, l_next, r_prev, r_next;

    if (k == 0) begin : g_head
      assign l_prev = head_l_in;
      assign r_prev = l_q[0];
    end else begin : g_body
      assign l_prev = l_q[k-1];
      assign r_prev = r_q[k-1];
    end

    if (k == HISTORY_DEPTH - 1) begin : g_tail
      assign l_next = l_q[k];
      assign r_next = r_q[k];
    end else begin : g_inner
      assign l_next = l_q[k+1];
      assign r_next = r_q[k+1];
    end

    buh_cell u_cell (
      .clk    (clk),
      .shift  (shift),
      .l_prev (l_prev),
      .l_next (l_next),
      .r_prev (r_prev),
      .r_next (r_next),
      .l_q    (l_q[k]),
      .r_q    (r_q[k])
    );
  end

endmodule

@@ rtl/buh_cell.sv @@
module buh_cell (
  input  logic                          clk,
  input  buh_pkg::shift_t               shift,
  input  logic [buh_pkg::ENTRY_W-1:0]   l_prev,
  input  logic [buh_pkg::ENTRY_W-1:0]   l_next,
  input  logic [buh_pkg::ENTRY_W-1:0]   r_prev,
  input  logic [buh_pkg::ENTRY_W-1:0]   r_next,
  output logic [buh_pkg::ENTRY_W-1:0]   l_q,
  output logic [buh_pkg::ENTRY_W-1:0]   r_q
);
  import buh_pkg::*;

  // The undo slot holds one entry below the cursor; the redo slot one above it.
  logic [ENTRY_W-1:0] l_r, l_nxt;
  logic [ENTRY_W-1:0] r_r, r_nxt;

  // Push and redo move the undo side away from the cursor, undo moves it back.
  always_comb begin
    l_nxt = l_r;
    r_nxt = r_r;
    case (shift)
      SH_PUSH: begin
        l_nxt = l_prev;
      end
      SH_UNDO: begin
        l_nxt = l_next;
        r_nxt = r_prev;
      end
      SH_REDO: begin
        l_nxt = l_prev;
        r_nxt = r_next;
      end
      default: begin
        l_nxt = l_r;
        r_nxt = r_r;
      end
    endcase
  end

  // Payload only, no reset needed.
  always_ff @(posedge clk) begin
    l_r <= l_nxt;
    r_r <= r_nxt;
  end

  assign l_q = l_r;
  assign r_q = r_r;

endmodule

@@ rtl/buh_ctrl.sv @@
`include "bounded_undo_redo_history_assert.svh"

module buh_ctrl #(
  parameter int HISTORY_DEPTH = buh_pkg::HISTORY_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [buh_pkg::OPCODE_W-1:0]      in_opcode,
  input  logic [buh_pkg::ENTRY_W-1:0]       in_entry_handle,
  input  logic [buh_pkg::ENTRY_W-1:0]       head_l,
  input  logic [buh_pkg::ENTRY_W-1:0]       head_r,
  output buh_pkg::shift_t                   shift,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              out_accepted,
  output logic [buh_pkg::ACTION_W-1:0]      out_action,
  output logic [buh_pkg::ENTRY_W-1:0]       out_entry_out,
  output logic [buh_pkg::UNDO_DEPTH_W-1:0]  out_undo_depth
);
  import buh_pkg::*;

  localparam int CNT_W = $clog2(HISTORY_DEPTH + 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(HISTORY_DEPTH);
  localparam logic [CNT_W-1:0] ONE_CNT  = CNT_W'(1);

  // Cursor and count of valid entries.
  logic [CNT_W-1:0] pos_r, pos_nxt;
  logic [CNT_W-1:0] lim_r, lim_nxt;

  // Result register.
  logic                    out_valid_r, out_valid_nxt;
  logic                    acc_r, acc_nxt;
  action_t                 act_r, act_nxt;
  logic [ENTRY_W-1:0]      ent_r, ent_nxt;
  logic [UNDO_DEPTH_W-1:0] depth_r;

  logic    xfer_in;
  shift_t  shift_op;

  // A new item enters whenever the result register is free or drains this cycle.
  assign in_stall = out_valid_r & out_stall;
  assign xfer_in  = in_valid & ~in_stall;

  // Decode the operation against the current cursor and limit.
  always_comb begin
    pos_nxt  = pos_r;
    lim_nxt  = lim_r;
    acc_nxt  = 1'b0;
    act_nxt  = ACT_NONE;
    ent_nxt  = '0;
    shift_op = SH_HOLD;
    case (op_t'(in_opcode))
      OP_PUSH_EXEC, OP_PUSH_ONLY: begin
        shift_op = SH_PUSH;
        pos_nxt  = (pos_r == FULL_CNT) ? pos_r : pos_r + ONE_CNT;
        lim_nxt  = pos_nxt;
        acc_nxt  = 1'b1;
        if (op_t'(in_opcode) == OP_PUSH_EXEC) begin
          act_nxt = ACT_EXEC;
          ent_nxt = in_entry_handle;
        end
      end
      OP_UNDO: begin
        if (pos_r != '0) begin
          shift_op = SH_UNDO;
          pos_nxt  = pos_r - ONE_CNT;
          acc_nxt  = 1'b1;
          act_nxt  = ACT_REVERT;
          ent_nxt  = head_l;
        end
      end
      OP_REDO: begin
        if (pos_r != lim_r) begin
          shift_op = SH_REDO;
          pos_nxt  = pos_r + ONE_CNT;
          acc_nxt  = 1'b1;
          act_nxt  = ACT_EXEC;
          ent_nxt  = head_r;
        end
      end
      OP_CLEAR: begin
        pos_nxt = '0;
        lim_nxt = '0;
        acc_nxt = 1'b1;
      end
      default: begin
        pos_nxt = pos_r;
      end
    endcase
  end

  // The cell row moves only on an input transfer.
  assign shift = xfer_in ? shift_op : SH_HOLD;

  // Result valid stays up while stalled and drops once taken, unless a new item enters.
  assign out_valid_nxt = xfer_in | (out_valid_r & out_stall);

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      lim_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (xfer_in) begin
        pos_r <= pos_nxt;
        lim_r <= lim_nxt;
      end
    end
  end

  // Result payload loads only on an input transfer.
  always_ff @(posedge clk) begin
    if (xfer_in) begin
      acc_r   <= acc_nxt;
      act_r   <= act_nxt;
      ent_r   <= ent_nxt;
      depth_r <= UNDO_DEPTH_W'(pos_nxt);
    end
  end

  assign out_valid      = out_valid_r;
  assign out_accepted   = acc_r;
  assign out_action     = act_r;
  assign out_entry_out  = ent_r;
  assign out_undo_depth = depth_r;

  // Checks on cursor bookkeeping and result coding.
  `BUH_ASSERT_NOW(a_pos_le_lim, 1'b1, pos_r <= lim_r, "cursor above redo limit")
  `BUH_ASSERT_NOW(a_lim_le_depth, 1'b1, lim_r <= FULL_CNT, "redo limit above depth")
  `BUH_ASSERT_NEXT(a_undo_steps, xfer_in && shift_op == SH_UNDO,
    pos_r == $past(pos_r) - ONE_CNT, "undo did not step cursor back")
  `BUH_ASSERT_NOW(a_action_accepted, out_valid_r && act_r != ACT_NONE, acc_r,
    "action reported on a rejected operation")

endmodule
